### rtl/core/tspcm_pkg.sv
// ----------------------------------------------------------------------------
// tspcm_pkg: transport stream PID continuity monitor types
// Header byte transfer, result transfer, PID slot entry and shared constants.
// ----------------------------------------------------------------------------
package tspcm_pkg;

  localparam int unsigned PidSlotsDefault = 32;

  localparam logic [7:0] SyncValue = 8'h47;
  localparam int unsigned PidW = 13;
  localparam int unsigned CcW = 4;
  localparam int unsigned CountW = 32;
  localparam int unsigned SlotIdxW = 5;

  // Header bytes 0..5 of one packet
  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] flags_pid_high;
    logic [7:0] pid_low;
    logic [7:0] scramble_afc_cc;
    logic [7:0] adapt_length;
    logic [7:0] adapt_flags;
  } ts_in_t;

  typedef struct packed {
    logic                status;
    logic [31:0]         packet_number;
    logic [PidW-1:0]     packet_pid;
    logic [SlotIdxW-1:0] slot_index;
    logic                new_pid;
    logic                table_full;
    logic                cc_discontinuity;
    logic                scramble_changed;
    logic [CountW-1:0]   pid_packet_count;
  } ts_out_t;

  // One PID table entry
  typedef struct packed {
    logic [PidW-1:0]   pid;
    logic              scrambled;
    logic [CcW-1:0]    last_cc;
    logic [CountW-1:0] count;
  } slot_t;

endpackage

### rtl/core/ts_pid_continuity_monitor.sv
// ----------------------------------------------------------------------------
// ts_pid_continuity_monitor: MPEG-TS continuity counter checker
// Checks sync, tracks PIDs in a slot table and flags counter and scrambling
// changes, one result per packet header.
// ----------------------------------------------------------------------------
// One header transfer gives one result transfer. A header with a bad sync
// byte goes straight to the finish state, which loads its result into the
// output register once that register is free. A good header searches the
// PID table one slot per cycle through a single memory read port and one
// PID comparator. A hit ends the search at the matching slot; a miss ends
// it after all used slots, at most PID_SLOTS of them. The next header is
// accepted once the result is loaded and the block is idle again. The
// input stalls while a header is in work. A finished result waits in the
// output register while the next header is searched. That header's result
// then holds until the output register is free. The table needs no
// clearing pass: only slots below the fill count are ever read.
module ts_pid_continuity_monitor
  import tspcm_pkg::*;
#(
  parameter int unsigned PID_SLOTS = PidSlotsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  ts_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output ts_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(PID_SLOTS + 1);
  localparam int unsigned AddrW = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
  localparam logic [CntW-1:0] SlotsMax = CntW'(PID_SLOTS);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  logic [31:0]      pkt_cnt_q, pkt_cnt_d;
  logic             out_valid_q, out_valid_d;
  ts_out_t          out_q, out_d;
  ts_out_t          res_q, res_d;

  logic [PidW-1:0]  pid_q, pid_d;
  logic             scr_q, scr_d;
  logic [CcW-1:0]   cc_q, cc_d;
  logic             disc_q, disc_d;

  slot_t            mem_q [PID_SLOTS];
  slot_t            rd_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  slot_t            wr_data;

  logic             in_xfer;
  logic             out_free;
  logic             issue;
  logic             hit;
  logic [CcW-1:0]   cc_step;
  logic [31:0]      hit_idx_ext;
  logic [31:0]      new_idx_ext;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign issue       = (idx_q < used_q);
  assign hit         = cmp_vld_q && (rd_q.pid == pid_q);
  assign cc_step     = cc_q - rd_q.last_cc;
  assign hit_idx_ext = 32'(cmp_idx_q);
  assign new_idx_ext = 32'(used_q);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    pkt_cnt_d   = pkt_cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res_d       = res_q;
    pid_d       = pid_q;
    scr_d       = scr_q;
    cc_d        = cc_q;
    disc_d      = disc_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_q;
    wr_data     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          pkt_cnt_d           = pkt_cnt_q + 32'd1;
          res_d               = '0;
          res_d.packet_number = pkt_cnt_q + 32'd1;
          pid_d  = {in_data_i.flags_pid_high[4:0], in_data_i.pid_low};
          scr_d  = in_data_i.scramble_afc_cc[7];
          cc_d   = in_data_i.scramble_afc_cc[3:0];
          // discontinuity flag only counts with an adaptation field present
          disc_d = in_data_i.scramble_afc_cc[5] && (in_data_i.adapt_length != 8'd0)
                   && in_data_i.adapt_flags[7];
          idx_d  = '0;
          if (in_data_i.sync_byte != SyncValue) begin
            res_d.status = 1'b1;
            state_d      = StFinish;
          end else begin
            res_d.packet_pid = {in_data_i.flags_pid_high[4:0], in_data_i.pid_low};
            state_d          = StSearch;
          end
        end
      end
      StSearch: begin
        if (hit) begin
          wr_en                  = 1'b1;
          wr_addr                = cmp_idx_q;
          wr_data.pid            = rd_q.pid;
          wr_data.scrambled      = scr_q;
          wr_data.last_cc        = cc_q;
          wr_data.count          = rd_q.count + 32'd1;
          res_d.slot_index       = hit_idx_ext[SlotIdxW-1:0];
          res_d.cc_discontinuity = (cc_step != CcW'(1)) && !disc_q;
          res_d.scramble_changed = (rd_q.scrambled != scr_q);
          res_d.pid_packet_count = rd_q.count + 32'd1;
          state_d                = StFinish;
        end else if (issue) begin
          // read slot idx now, compare it next cycle
          rd_en     = 1'b1;
          rd_addr   = idx_q[AddrW-1:0];
          idx_d     = idx_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AddrW-1:0];
        end else begin
          // every used slot compared without a match
          if (used_q < SlotsMax) begin
            wr_en                  = 1'b1;
            wr_addr                = used_q[AddrW-1:0];
            wr_data.pid            = pid_q;
            wr_data.scrambled      = scr_q;
            wr_data.last_cc        = cc_q;
            wr_data.count          = 32'd1;
            used_d                 = used_q + CntW'(1);
            res_d.slot_index       = new_idx_ext[SlotIdxW-1:0];
            res_d.new_pid          = 1'b1;
            res_d.pid_packet_count = 32'd1;
          end else begin
            res_d.table_full = 1'b1;
          end
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      pkt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      pkt_cnt_q   <= pkt_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    out_q     <= out_d;
    res_q     <= res_d;
    pid_q     <= pid_d;
    scr_q     <= scr_d;
    cc_q      <= cc_d;
    disc_q    <= disc_d;
  end

  // PID table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SlotsMax)
    else $error("slot fill count beyond table size");

  a_wr_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == StSearch))
    else $error("table write outside search");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch && hit) |-> (CntW'(cmp_idx_q) < used_q))
    else $error("hit on a slot that was never filled");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StFinish))
    else $error("result presented without finishing a search");

  a_bad_sync_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status) |-> (out_q.packet_pid == '0 && !out_q.new_pid
                                       && out_q.pid_packet_count == '0))
    else $error("bad sync result carries table fields");

endmodule

### verif/tb_ts_pid_continuity_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ts_pid_continuity_monitor: self-checking bench for the PID continuity monitor
// Sends transport stream headers with random idle and stall, tracks its own
// PID table per accepted header and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_ts_pid_continuity_monitor;
  import tspcm_pkg::*;

  localparam int unsigned TblSlots = PidSlotsDefault;
  localparam int PoolSize = 48;
  localparam int HoldoffCycles = 400;
  localparam int DrainCycles = 60;
  localparam int CycleLimit = 400000;
  localparam int MaxReports = 10;

  localparam logic StatusOk = 1'b0;
  localparam logic StatusNoSync = 1'b1;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  ts_in_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  ts_out_t out_data_o;

  always #5 clk_i = ~clk_i;

  ts_pid_continuity_monitor u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // PID table as the block should hold it
  logic [PidW-1:0]   tbl_pid[TblSlots];
  logic              tbl_scrambled[TblSlots];
  logic [CcW-1:0]    tbl_cc[TblSlots];
  logic [CountW-1:0] tbl_count[TblSlots];
  int                tbl_used = 0;
  logic [31:0]       total_packets = '0;

  ts_out_t pending_status_q[$];
  int      fail_count = 0;
  int      idle_pct = 35;
  int      cycle_count = 0;

  // hold-off request: the stall process picks up each change of the sequence
  int holdoff_seq = 0;
  int holdoff_ack = 0;
  int holdoff_left = 0;

  // per-stream state of the stimulus
  logic [PidW-1:0] stream_pid[PoolSize];
  logic [CcW-1:0]  stream_cc[PoolSize];
  logic            stream_scr[PoolSize];

  ts_out_t want_status;

  function automatic ts_out_t predict_pid_status(input ts_in_t hdr);
    ts_out_t         res;
    logic [PidW-1:0] pid;
    logic [CcW-1:0]  cc;
    logic [CcW-1:0]  cc_step;
    logic            scr;
    logic            disc_ok;
    int              hit;
    int              i;
    res = '0;
    total_packets = total_packets + 32'd1;
    res.packet_number = total_packets;
    if (hdr.sync_byte != SyncValue) begin
      res.status = StatusNoSync;
      return res;
    end
    res.status = StatusOk;
    pid = {hdr.flags_pid_high[4:0], hdr.pid_low};
    scr = hdr.scramble_afc_cc[7];
    cc = hdr.scramble_afc_cc[3:0];
    // indicator counts only with an adaptation field of nonzero length
    disc_ok = hdr.scramble_afc_cc[5] && (hdr.adapt_length != 8'd0) && hdr.adapt_flags[7];
    res.packet_pid = pid;
    hit = -1;
    for (i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_pid[i] == pid) hit = i;
    end
    if (hit >= 0) begin
      cc_step = cc - tbl_cc[hit];
      res.cc_discontinuity = (cc_step != 4'd1) && !disc_ok;
      res.scramble_changed = (tbl_scrambled[hit] != scr);
      tbl_scrambled[hit] = scr;
      tbl_cc[hit] = cc;
      tbl_count[hit] = tbl_count[hit] + 32'd1;
      res.slot_index = SlotIdxW'(hit);
      res.pid_packet_count = tbl_count[hit];
    end else if (tbl_used < TblSlots) begin
      tbl_pid[tbl_used] = pid;
      tbl_scrambled[tbl_used] = scr;
      tbl_cc[tbl_used] = cc;
      tbl_count[tbl_used] = 32'd1;
      res.slot_index = SlotIdxW'(tbl_used);
      res.new_pid = 1'b1;
      res.pid_packet_count = 32'd1;
      tbl_used++;
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  function automatic ts_in_t build_header(input logic [2:0] top_flags,
                                          input logic [PidW-1:0] pid,
                                          input logic [1:0] scr_ctl,
                                          input logic [1:0] afc,
                                          input logic [CcW-1:0] cc,
                                          input logic [7:0] alen,
                                          input logic [7:0] aflags);
    ts_in_t hdr;
    hdr.sync_byte = SyncValue;
    hdr.flags_pid_high = {top_flags, pid[12:8]};
    hdr.pid_low = pid[7:0];
    hdr.scramble_afc_cc = {scr_ctl, afc, cc};
    hdr.adapt_length = alen;
    hdr.adapt_flags = aflags;
    return hdr;
  endfunction

  function automatic string fmt_status(input ts_out_t r);
    return $sformatf("st=%0d num=%0d pid=%h slot=%0d new=%0d full=%0d cc=%0d scr=%0d cnt=%0d",
                     r.status, r.packet_number, r.packet_pid, r.slot_index, r.new_pid,
                     r.table_full, r.cc_discontinuity, r.scramble_changed, r.pid_packet_count);
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MaxReports) $display("%0t: %s", $time, what);
  endtask

  // one header transfer; called right after a rising edge
  task automatic send_header(input ts_in_t hdr);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= hdr;
    do @(posedge clk_i); while (in_stall_o);
    pending_status_q.push_back(predict_pid_status(hdr));
  endtask

  task automatic test_sync_errors();
    ts_in_t     hdr;
    logic [7:0] bad_sync[4];
    int         k;
    bad_sync = '{8'h00, 8'hFF, 8'h46, 8'hB8};
    for (k = 0; k < 4; k++) begin
      hdr = build_header(3'($urandom), 13'($urandom), 2'($urandom), 2'($urandom),
                         4'($urandom), 8'($urandom), 8'($urandom));
      hdr.sync_byte = bad_sync[k];
      send_header(hdr);
    end
  endtask

  task automatic test_header_fields();
    ts_in_t hdr;
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b01, 4'd5, 8'h00, 8'h00));
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b01, 4'd6, 8'h00, 8'h00));
    // repeated counter
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b01, 4'd6, 8'h00, 8'h00));
    // discontinuity honored
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b11, 4'd6, 8'h01, 8'h80));
    // indicator set but no adaptation field
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b01, 4'd12, 8'h07, 8'hFF));
    // indicator set but zero-length adaptation field
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b10, 4'd2, 8'h00, 8'h80));
    send_header(build_header(3'b000, 13'h0000, 2'b10, 2'b01, 4'd3, 8'h00, 8'h00));
    // only the top scrambling bit counts
    send_header(build_header(3'b000, 13'h0000, 2'b01, 2'b01, 4'd4, 8'h00, 8'h00));
    send_header(build_header(3'b111, 13'h1FFF, 2'b11, 2'b11, 4'd15, 8'hFF, 8'h7F));
    // counter wraps 15 -> 0
    send_header(build_header(3'b111, 13'h1FFF, 2'b11, 2'b11, 4'd0, 8'hFF, 8'h7F));
    send_header(build_header(3'b111, 13'h1FFF, 2'b11, 2'b11, 4'd0, 8'hFF, 8'hFF));
    // bad sync in between leaves the table alone
    hdr = build_header(3'b000, 13'h0000, 2'b00, 2'b01, 4'd9, 8'h00, 8'h00);
    hdr.sync_byte = 8'h07;
    send_header(hdr);
    send_header(build_header(3'b000, 13'h0000, 2'b00, 2'b01, 4'd5, 8'h00, 8'h00));
    send_header(build_header(3'b101, 13'h1000, 2'b00, 2'b00, 4'd1, 8'h55, 8'hAA));
    send_header(build_header(3'b010, 13'h00FF, 2'b10, 2'b11, 4'd8, 8'hAA, 8'h55));
  endtask

  // mostly well-formed per-PID streams, some counter and scrambling faults,
  // and a share of raw noise
  task automatic test_random_streams(input int count, input int pool_size);
    ts_in_t         hdr;
    logic [63:0]    noise_bits;
    logic [CcW-1:0] cc;
    logic [7:0]     alen;
    int             idx;
    int             pick;
    repeat (count) begin
      idx = $urandom_range(0, pool_size - 1);
      if ($urandom_range(0, 99) < 8) begin
        noise_bits = {$urandom, $urandom};
        hdr = noise_bits[47:0];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 85) cc = stream_cc[idx] + 4'd1;
        else if (pick < 93) cc = stream_cc[idx];
        else cc = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 5) stream_scr[idx] = ~stream_scr[idx];
        alen = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        hdr = build_header(3'($urandom), stream_pid[idx], {stream_scr[idx], 1'($urandom)},
                           2'($urandom), cc, alen, 8'($urandom));
        stream_cc[idx] = cc;
      end
      send_header(hdr);
    end
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    test_random_streams(200, 20);
    idle_pct = 35;
  endtask

  task automatic test_output_holdoff();
    idle_pct = 0;
    holdoff_seq <= holdoff_seq + 1;
    test_random_streams(30, 20);
    idle_pct = 35;
  endtask

  // receiver side stall
  always @(posedge clk_i) begin
    if (holdoff_seq != holdoff_ack) begin
      holdoff_ack = holdoff_seq;
      holdoff_left = HoldoffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status_q.size() == 0) begin
        note_failure($sformatf("unexpected result %s", fmt_status(out_data_o)));
      end else begin
        want_status = pending_status_q.pop_front();
        if (want_status.status !== out_data_o.status ||
            want_status.packet_number !== out_data_o.packet_number ||
            want_status.packet_pid !== out_data_o.packet_pid ||
            want_status.slot_index !== out_data_o.slot_index ||
            want_status.new_pid !== out_data_o.new_pid ||
            want_status.table_full !== out_data_o.table_full ||
            want_status.cc_discontinuity !== out_data_o.cc_discontinuity ||
            want_status.scramble_changed !== out_data_o.scramble_changed ||
            want_status.pid_packet_count !== out_data_o.pid_packet_count) begin
          note_failure($sformatf("mismatch exp %s | act %s",
                                 fmt_status(want_status), fmt_status(out_data_o)));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : main_seq
    int k;
    for (k = 0; k < PoolSize; k++) begin
      stream_pid[k] = 13'($urandom);
      stream_cc[k] = 4'($urandom);
      stream_scr[k] = 1'($urandom);
    end
    stream_pid[0] = 13'h0000;
    stream_pid[1] = 13'h1FFF;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sync_errors();
    test_header_fields();
    test_random_streams(300, 20);
    test_back_to_back();
    test_output_holdoff();
    // wider pool fills the table and then runs into table full
    test_random_streams(650, PoolSize);

    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### ts_pid_continuity_monitor.f
rtl/core/tspcm_pkg.sv
rtl/core/ts_pid_continuity_monitor.sv
verif/tb_ts_pid_continuity_monitor.sv
